/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the dither core datapath.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked assertion, disabled while reset is asserted.
`define EDP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define EDP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EDP_ASSERT(lbl, clk, rst_n, prop, msg)
`define EDP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* src/edp_pkg.sv */
// ----------------------------------------------------------------------------
// edp_pkg
// Widths, codes and controller/datapath bundles of the palette dither core.
// ----------------------------------------------------------------------------
package edp_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int PAL_DEPTH  = 256;
	localparam int FRAC_BITS  = 8;

	localparam int CH_W       = 8;
	localparam int COLOR_W    = 3 * CH_W;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ERR_AW     = COL_W + 1;
	localparam int PAL_AW     = $clog2(PAL_DEPTH);
	localparam int K_W        = PAL_AW + 1;
	localparam int CUR_W      = CH_W + FRAC_BITS;
	localparam int ERR_W      = CUR_W + 2;
	localparam int SUM_W      = ERR_W + 2;
	localparam int SQ_W       = 2 * CUR_W;
	localparam int DIST_W     = SQ_W + 2;

	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 16;
	localparam int PSIZE_W    = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SIZE = 2'd2;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	typedef struct packed {
		logic capture;
		logic pal_write;
		logic err_read;
		logic clamp;
		logic search_start;
		logic search_issue;
		logic weight;
		logic update;
		logic tail;
		logic post;
	} cmd_t;

	typedef struct packed {
		logic issue_last;
		logic pipe_busy;
		logic last_col;
		logic out_busy;
	} status_t;

endpackage

/* src/edp_ifs.sv */
// ----------------------------------------------------------------------------
// Dither core channels
// Valid/ready channels for pixel commands and for chosen palette indexes.
// ----------------------------------------------------------------------------
interface edp_pixel_if;
	logic                     valid;
	logic                     ready;
	logic                     command;
	logic [edp_pkg::CH_W-1:0] entry_index;
	logic [edp_pkg::CH_W-1:0] red;
	logic [edp_pkg::CH_W-1:0] green;
	logic [edp_pkg::CH_W-1:0] blue;

	modport source (output valid, command, entry_index, red, green, blue, input ready);
	modport sink (input valid, command, entry_index, red, green, blue, output ready);
endinterface

interface edp_index_if;
	logic                     valid;
	logic                     ready;
	logic [edp_pkg::CH_W-1:0] color_index;
	logic                     image_end;

	modport source (output valid, color_index, image_end, input ready);
	modport sink (input valid, color_index, image_end, output ready);
endinterface

/* src/edp_ctrl.sv */
// ----------------------------------------------------------------------------
// edp_ctrl
// Sequencer of one command: load, or error fetch, search, diffusion, result.
// ----------------------------------------------------------------------------
module edp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_command,
	input  edp_pkg::status_t status,
	output logic             in_ready,
	output edp_pkg::cmd_t    cmd
);
	import edp_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_ERR_RD = 9'b000000010,
		ST_CLAMP  = 9'b000000100,
		ST_SEARCH = 9'b000001000,
		ST_DRAIN  = 9'b000010000,
		ST_WEIGHT = 9'b000100000,
		ST_UPDATE = 9'b001000000,
		ST_TAIL   = 9'b010000000,
		ST_POST   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture   = accept;
				cmd.pal_write = accept & (in_command == CMD_LOAD);
				if (accept && in_command == CMD_PIXEL) state_d = ST_ERR_RD;
			end
			ST_ERR_RD: begin
				cmd.err_read = 1'b1;
				state_d      = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.clamp        = 1'b1;
				cmd.search_start = 1'b1;
				state_d          = ST_SEARCH;
			end
			ST_SEARCH: begin
				cmd.search_issue = 1'b1;
				if (status.issue_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) state_d = ST_WEIGHT;
			end
			ST_WEIGHT: begin
				cmd.weight = 1'b1;
				state_d    = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = status.last_col ? ST_TAIL : ST_POST;
			end
			ST_TAIL: begin
				cmd.tail = 1'b1;
				state_d  = ST_POST;
			end
			ST_POST: begin
				if (!status.out_busy) begin
					cmd.post = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

endmodule

/* src/edp_datapath.sv */
// ----------------------------------------------------------------------------
// edp_datapath
// Registers, palette and error memories, search pipeline and diffusion math.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module edp_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  edp_pkg::cmd_t                     cmd,
	input  logic [edp_pkg::CH_W-1:0]          entry_index,
	input  logic [edp_pkg::CH_W-1:0]          red,
	input  logic [edp_pkg::CH_W-1:0]          green,
	input  logic [edp_pkg::CH_W-1:0]          blue,
	input  logic                              cfg_we,
	input  logic [edp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [edp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [edp_pkg::CH_W-1:0]          color_index,
	output logic                              image_end,
	output edp_pkg::status_t                  status
);
	import edp_pkg::*;

	localparam logic [CUR_W-1:0] TOP_VAL = CUR_W'(255 << FRAC_BITS);

	// configuration
	logic [WIDTH_W-1:0]  width_q, w_eff;
	logic [HEIGHT_W-1:0] height_q, h_eff;
	logic [PSIZE_W-1:0]  psize_q, n_eff;
	logic                restart;

	// position
	logic [COL_W-1:0]    col_q, x_eff;
	logic [HEIGHT_W-1:0] row_q;
	logic                bank_q, first_row_q;
	logic                last_col, last_row;

	// memories
	logic [3*ERR_W-1:0]  err_mem [2*MAX_WIDTH];
	logic [3*ERR_W-1:0]  err_rd_s1;
	logic [COLOR_W-1:0]  pal_mem [PAL_DEPTH];
	logic                err_we;
	logic [ERR_AW-1:0]   err_wa;
	logic [3*ERR_W-1:0]  err_wd;

	// pixel and diffusion state
	logic [CH_W-1:0]         px_q    [3];
	logic [CUR_W-1:0]        cur_q   [3];
	logic signed [ERR_W-1:0] right_q [3];
	logic signed [ERR_W-1:0] b0_q    [3];
	logic signed [ERR_W-1:0] b1_q    [3];
	logic signed [ERR_W-1:0] t7_q    [3];
	logic signed [ERR_W-1:0] t5_q    [3];
	logic signed [ERR_W-1:0] t3_q    [3];
	logic signed [ERR_W-1:0] t1_q    [3];
	logic signed [ERR_W-1:0] b0_t3   [3];

	// search pipeline
	logic [K_W-1:0]      k_q;
	logic                v_s1, v_s2;
	logic [COLOR_W-1:0]  pal_rd_s1, col_s2;
	logic [PAL_AW-1:0]   k_s1, k_s2;
	logic [SQ_W-1:0]     sq_s2 [3];
	logic [DIST_W-1:0]   dist_sum;
	logic [DIST_W-1:0]   best_d_q;
	logic [PAL_AW-1:0]   best_k_q;
	logic [COLOR_W-1:0]  best_col_q;

	// output register
	logic                out_valid_q;
	logic [CH_W-1:0]     color_index_q;
	logic                image_end_q;

	function automatic logic [CH_W-1:0] chan(input logic [COLOR_W-1:0] c, input int i);
		chan = c[COLOR_W-1-CH_W*i -: CH_W];
	endfunction

	// ---------------- configuration ----------------
	assign restart = cfg_we &&
		(cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(1);
			height_q <= HEIGHT_W'(1);
			psize_q  <= PSIZE_W'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
				CFG_PALETTE_SIZE: psize_q  <= cfg_data[PSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0)                     w_eff = WIDTH_W'(1);
		else if (32'(width_q) > MAX_WIDTH)     w_eff = WIDTH_W'(MAX_WIDTH);
		else                                   w_eff = width_q;
		h_eff = (height_q == '0) ? HEIGHT_W'(1) : height_q;
		if (psize_q < PSIZE_W'(2))             n_eff = PSIZE_W'(2);
		else if (32'(psize_q) > PAL_DEPTH)     n_eff = PSIZE_W'(PAL_DEPTH);
		else                                   n_eff = psize_q;
	end

	// ---------------- position ----------------
	assign x_eff    = (WIDTH_W'(col_q) >= w_eff) ? '0 : col_q;
	assign last_col = (WIDTH_W'(x_eff) + WIDTH_W'(1)) >= w_eff;
	assign last_row = ({1'b0, row_q} + (HEIGHT_W+1)'(1)) >= {1'b0, h_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			bank_q      <= 1'b0;
			first_row_q <= 1'b1;
		end else if (restart || (cmd.post && last_col && last_row)) begin
			col_q       <= '0;
			row_q       <= '0;
			bank_q      <= 1'b0;
			first_row_q <= 1'b1;
		end else if (cmd.post) begin
			if (last_col) begin
				col_q       <= '0;
				row_q       <= row_q + HEIGHT_W'(1);
				bank_q      <= ~bank_q;
				first_row_q <= 1'b0;
			end else begin
				col_q <= x_eff + COL_W'(1);
			end
		end
	end

	// ---------------- palette store ----------------
	always_ff @(posedge clk) begin
		if (cmd.pal_write && 32'(entry_index) < PAL_DEPTH)
			pal_mem[entry_index[PAL_AW-1:0]] <= {red, green, blue};
		if (cmd.search_issue)
			pal_rd_s1 <= pal_mem[k_q[PAL_AW-1:0]];
	end

	// ---------------- error rows ----------------
	// Rows of the below bank are overwritten in full, so only the first row
	// of an image needs its read masked.
	always_comb begin
		for (int c = 0; c < 3; c++) b0_t3[c] = b0_q[c] + t3_q[c];
		err_we = !last_row && ((cmd.update && x_eff != '0) || cmd.tail);
		if (cmd.update) begin
			err_wa = {~bank_q, x_eff - COL_W'(1)};
			err_wd = {b0_t3[0], b0_t3[1], b0_t3[2]};
		end else begin
			err_wa = {~bank_q, x_eff};
			err_wd = {b0_q[0], b0_q[1], b0_q[2]};
		end
	end

	always_ff @(posedge clk) begin
		if (err_we)
			err_mem[err_wa] <= err_wd;
		if (cmd.err_read)
			err_rd_s1 <= err_mem[{bank_q, x_eff}];
	end

	// ---------------- capture and clamp ----------------
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			px_q[0] <= red;
			px_q[1] <= green;
			px_q[2] <= blue;
		end
		if (cmd.clamp) begin
			for (int c = 0; c < 3; c++) begin
				logic signed [SUM_W-1:0] s;
				logic signed [ERR_W-1:0] er;
				er = first_row_q ? '0 : signed'(err_rd_s1[3*ERR_W-1-ERR_W*c -: ERR_W]);
				s = signed'(SUM_W'({px_q[c], {FRAC_BITS{1'b0}}})) + SUM_W'(er)
					+ SUM_W'(right_q[c]);
				if (s < 0)                              cur_q[c] <= '0;
				else if (s > signed'(SUM_W'(TOP_VAL)))  cur_q[c] <= TOP_VAL;
				else                                    cur_q[c] <= s[CUR_W-1:0];
			end
		end
	end

	// ---------------- nearest entry search ----------------
	always_comb begin
		dist_sum = DIST_W'(sq_s2[0]) + DIST_W'(sq_s2[1]) + DIST_W'(sq_s2[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (cmd.search_start)      k_q <= '0;
			else if (cmd.search_issue) k_q <= k_q + K_W'(1);
			v_s1 <= cmd.search_issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		k_s1   <= k_q[PAL_AW-1:0];
		k_s2   <= k_s1;
		col_s2 <= pal_rd_s1;
		for (int c = 0; c < 3; c++) begin
			logic signed [CUR_W:0] d;
			logic [CUR_W-1:0]      a;
			d = signed'({1'b0, cur_q[c]}) - signed'({1'b0, chan(pal_rd_s1, c),
				{FRAC_BITS{1'b0}}});
			a = (d < 0) ? CUR_W'(-d) : d[CUR_W-1:0];
			sq_s2[c] <= a * a;
		end
		if (cmd.search_start) begin
			best_d_q <= '1;
			best_k_q <= '0;
		end else if (v_s2 && dist_sum < best_d_q) begin
			best_d_q   <= dist_sum;
			best_k_q   <= k_s2;
			best_col_q <= col_s2;
		end
	end

	// ---------------- diffusion ----------------
	always_ff @(posedge clk) begin
		if (cmd.weight) begin
			for (int c = 0; c < 3; c++) begin
				logic signed [ERR_W-1:0] e;
				logic signed [ERR_W+2:0] ex, p7, p5, p3;
				e  = signed'(ERR_W'(cur_q[c])) -
					signed'(ERR_W'({chan(best_col_q, c), {FRAC_BITS{1'b0}}}));
				ex = {{3{e[ERR_W-1]}}, e};
				p7 = (ex <<< 3) - ex;
				p5 = (ex <<< 2) + ex;
				p3 = (ex <<< 1) + ex;
				t7_q[c] <= ERR_W'(p7 >>> 4);
				t5_q[c] <= ERR_W'(p5 >>> 4);
				t3_q[c] <= ERR_W'(p3 >>> 4);
				t1_q[c] <= ERR_W'(ex >>> 4);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				right_q[c] <= '0;
				b0_q[c]    <= '0;
				b1_q[c]    <= '0;
			end
		end else if (restart) begin
			for (int c = 0; c < 3; c++) begin
				right_q[c] <= '0;
				b1_q[c]    <= '0;
			end
		end else if (cmd.update) begin
			for (int c = 0; c < 3; c++) begin
				b0_q[c]    <= b1_q[c] + t5_q[c];
				b1_q[c]    <= last_col ? '0 : t1_q[c];
				right_q[c] <= last_col ? '0 : t7_q[c];
			end
		end
	end

	// ---------------- result ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        out_valid_q <= 1'b0;
		else if (cmd.post)  out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.post) begin
			color_index_q <= CH_W'(best_k_q);
			image_end_q   <= last_col & last_row;
		end
	end

	assign out_valid   = out_valid_q;
	assign color_index = color_index_q;
	assign image_end   = image_end_q;

	assign status.issue_last = (k_q == K_W'(n_eff - PSIZE_W'(1)));
	assign status.pipe_busy  = v_s1 | v_s2;
	assign status.last_col   = last_col;
	assign status.out_busy   = out_valid_q & ~out_ready;

	`EDP_ASSERT(a_pipe_advance, clk, arst_n, v_s1 |=> v_s2, "search pipeline lost an entry")
	`EDP_ASSERT(a_first_row, clk, arst_n, first_row_q |-> row_q == '0, "first row flag off row 0")
	`EDP_ASSERT(a_best_hold, clk, arst_n, (!v_s2 && !cmd.search_start) |=> $stable(best_k_q),
		"best index moved outside compare")

endmodule

/* src/error_diffusion_palette_dither_core.sv */
// ----------------------------------------------------------------------------
// error_diffusion_palette_dither_core
// Floyd-Steinberg dither onto a loaded palette, nearest entry by RGB distance.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  pixels    in   valid/ready    command, entry_index, red, green, blue
//  indices   out  valid/ready    color_index, image_end
//  cfg       in   cfg_we         cfg_index, cfg_data (no read-back)
//
//  A load transaction writes its palette entry; the core stays idle and ready.
//  A pixel transaction runs error read, clamp, search (one palette entry a
//  cycle), drain, weight, update, tail (last column only) and post.
//  A finished result sits in the output register; the core takes the next
//  transaction meanwhile and stalls only when a second result is due.
//  Reset clears counters and control at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module error_diffusion_palette_dither_core (
	input  logic                           clk,
	input  logic                           arst_n,
	edp_pixel_if.sink                      pixels,
	edp_index_if.source                    indices,
	input  logic                           cfg_we,
	input  logic [edp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [edp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import edp_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequence each pixel transaction: fetch error, clamp, search, diffuse, post.
	edp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (pixels.valid),
		.in_command (pixels.command),
		.status     (status),
		.in_ready   (pixels.ready),
		.cmd        (cmd)
	);

	// Hold the palette, both error rows and the search pipeline.
	edp_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.entry_index (pixels.entry_index),
		.red         (pixels.red),
		.green       (pixels.green),
		.blue        (pixels.blue),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_ready   (indices.ready),
		.out_valid   (indices.valid),
		.color_index (indices.color_index),
		.image_end   (indices.image_end),
		.status      (status)
	);

endmodule

/* test/dither_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dither checker
// Watches the pixel, index and register channels of the dither core, predicts
// the chosen palette index and image end of every pixel transaction, and
// compares each index transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module dither_checker
	import edp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	edp_pixel_if                  pixels,
	edp_index_if                  indices,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    waiting
);

	typedef struct {
		logic [CH_W-1:0] color_index;
		logic            image_end;
	} dither_result_t;

	dither_result_t       expected_indices[$];
	logic [COLOR_W-1:0]   palette[PAL_DEPTH];
	int                   err_row[2][MAX_WIDTH][3];
	bit                   row_sel;
	int                   col_count;
	int                   row_count;
	int                   width_reg;
	int                   height_reg;
	int                   psize_reg;

	function automatic void restart_image();
		foreach (err_row[i, j, c])
			err_row[i][j][c] = 0;
		row_sel   = 0;
		col_count = 0;
		row_count = 0;
	endfunction

	task automatic dither_pixel(input logic [CH_W-1:0] r, g, b, output dither_result_t res);
		int     w, h, n, x, best;
		bit     cs, bs;
		int     ch[3];
		int     cur[3];
		int     e[3];
		int     pc, v;
		longint d, best_d, diff;
		w = (width_reg < 1) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
		h = (height_reg < 1) ? 1 : height_reg;
		n = (psize_reg < 2) ? 2 : (psize_reg > PAL_DEPTH) ? PAL_DEPTH : psize_reg;
		x = (col_count >= w) ? 0 : col_count;
		cs = row_sel;
		bs = !row_sel;
		ch[0] = r;
		ch[1] = g;
		ch[2] = b;
		for (int c = 0; c < 3; c++) begin
			v = (ch[c] << FRAC_BITS) + err_row[cs][x][c];
			if (v < 0) v = 0;
			if (v > (255 << FRAC_BITS)) v = 255 << FRAC_BITS;
			cur[c] = v;
		end
		// Strict less-than keeps the lowest index on a tie.
		best   = 0;
		best_d = -1;
		for (int k = 0; k < n; k++) begin
			d = 0;
			for (int c = 0; c < 3; c++) begin
				pc   = int'(palette[k][16 - 8 * c +: 8]) << FRAC_BITS;
				diff = cur[c] - pc;
				d   += diff * diff;
			end
			if (best_d < 0 || d < best_d) begin
				best_d = d;
				best   = k;
			end
		end
		// Arithmetic shift floors each weighted share.
		for (int c = 0; c < 3; c++) begin
			e[c] = cur[c] - (int'(palette[best][16 - 8 * c +: 8]) << FRAC_BITS);
			if (x + 1 < w) err_row[cs][x + 1][c] += (e[c] * 7) >>> 4;
			if (x > 0) err_row[bs][x - 1][c] += (e[c] * 3) >>> 4;
			err_row[bs][x][c] += (e[c] * 5) >>> 4;
			if (x + 1 < w) err_row[bs][x + 1][c] += e[c] >>> 4;
		end
		res.color_index = best[CH_W-1:0];
		res.image_end   = 1'b0;
		if (x + 1 >= w) begin
			col_count = 0;
			for (int j = 0; j < MAX_WIDTH; j++)
				for (int c = 0; c < 3; c++)
					err_row[cs][j][c] = 0;
			row_sel = bs;
			row_count++;
			if (row_count >= h) begin
				res.image_end = 1'b1;
				restart_image();
			end
		end else begin
			col_count = x + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		dither_result_t res, got;
		if (!arst_n) begin
			expected_indices.delete();
			foreach (palette[k])
				palette[k] = '0;
			restart_image();
			width_reg  = 1;
			height_reg = 1;
			psize_reg  = 2;
			mismatches = 0;
			waiting    = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH: begin
						width_reg = cfg_data[WIDTH_W-1:0];
						restart_image();
					end
					CFG_IMAGE_HEIGHT: begin
						height_reg = cfg_data[HEIGHT_W-1:0];
						restart_image();
					end
					CFG_PALETTE_SIZE: begin
						psize_reg = cfg_data[PSIZE_W-1:0];
					end
					default: ;
				endcase
			end
			if (pixels.valid && pixels.ready) begin
				if (pixels.command == CMD_LOAD) begin
					palette[pixels.entry_index] = {pixels.red, pixels.green, pixels.blue};
				end else begin
					dither_pixel(pixels.red, pixels.green, pixels.blue, res);
					expected_indices.push_back(res);
				end
			end
			if (indices.valid && indices.ready) begin
				got.color_index = indices.color_index;
				got.image_end   = indices.image_end;
				if (expected_indices.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected index %0d end %0b", $realtime,
							got.color_index, got.image_end);
				end else begin
					res = expected_indices.pop_front();
					if (got.color_index !== res.color_index || got.image_end !== res.image_end) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: index exp %0d got %0d, end exp %0b got %0b",
								$realtime, res.color_index, got.color_index,
								res.image_end, got.image_end);
					end
				end
			end
			waiting = expected_indices.size();
		end
	end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dither core testbench
// Loads the palette, sweeps image geometry and palette size through normal
// and out-of-range settings, and streams directed and random pixels with
// random gaps and output stalls; the checker judges every index transaction.
// ----------------------------------------------------------------------------
module tb_top;
	import edp_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    waiting;
	bit                    no_gaps;     // burst mode: no source gaps, no sink stalls
	int                    sink_hold;
	int                    pixels_sent;

	edp_pixel_if px();
	edp_index_if ix();

	error_diffusion_palette_dither_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixels   (px),
		.indices  (ix),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	dither_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (px),
		.indices   (ix),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.waiting   (waiting)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Hard stop in case the core hangs.
	initial begin
		#50000000;
		$display("Simulation FAILED");
		$finish;
	end

	// Output side: after each index transaction, draw a random stall length and
	// hold ready low while it counts down.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ix.ready  <= 1'b0;
			sink_hold <= 0;
		end else if (ix.valid && ix.ready) begin
			sink_hold <= no_gaps ? 0 : $urandom_range(0, 14);
			ix.ready  <= no_gaps;
		end else if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			ix.ready  <= 1'b0;
		end else begin
			ix.ready <= 1'b1;
		end
	end

	// Send one transaction on the pixel channel; valid stays high when the
	// next one follows with no gap.
	task automatic send(input logic cmd, input logic [7:0] idx, input logic [7:0] r,
		input logic [7:0] g, input logic [7:0] b);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			px.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		px.valid       <= 1'b1;
		px.command     <= cmd;
		px.entry_index <= idx;
		px.red         <= r;
		px.green       <= g;
		px.blue        <= b;
		@(posedge clk);
		while (!px.ready) @(posedge clk);
		if (cmd == CMD_PIXEL) pixels_sent++;
	endtask

	task automatic pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		send(CMD_PIXEL, 8'($urandom), r, g, b);
	endtask

	task automatic random_pixel();
		pixel(8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Drop valid and hold until every prediction has been answered, then let
	// any trailing load finish.
	task automatic drain();
		px.valid <= 1'b0;
		@(negedge clk);
		while (waiting != 0) @(negedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_geometry(input int w, input int h, input int n);
		drain();
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		write_reg(CFG_PALETTE_SIZE, n);
	endtask

	initial begin
		int w, h, n, span;
		px.valid       <= 1'b0;
		px.command     <= CMD_LOAD;
		px.entry_index <= '0;
		px.red         <= '0;
		px.green       <= '0;
		px.blue        <= '0;
		cfg_we         <= 1'b0;
		cfg_index      <= CFG_IMAGE_WIDTH;
		cfg_data       <= '0;
		no_gaps        = 1'b0;
		pixels_sent    = 0;
		arst_n         = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole palette so any palette size reads written entries:
		// black, white, a tied pair, pure primaries, the rest random.
		send(CMD_LOAD, 8'd0, 8'h00, 8'h00, 8'h00);
		send(CMD_LOAD, 8'd1, 8'hFF, 8'hFF, 8'hFF);
		send(CMD_LOAD, 8'd2, 8'h80, 8'h80, 8'h80);
		send(CMD_LOAD, 8'd3, 8'h80, 8'h80, 8'h80);
		send(CMD_LOAD, 8'd4, 8'hFF, 8'h00, 8'h00);
		send(CMD_LOAD, 8'd5, 8'h00, 8'hFF, 8'h00);
		send(CMD_LOAD, 8'd6, 8'h00, 8'h00, 8'hFF);
		no_gaps = 1'b1;
		for (int k = 7; k < PAL_DEPTH; k++)
			send(CMD_LOAD, k[7:0], 8'($urandom), 8'($urandom), 8'($urandom));
		no_gaps = 1'b0;

		// Directed: extremes of each channel on a small image, ties, width
		// zero and oversized, height zero and oversized, palette size below
		// and above range.
		set_geometry(3, 2, 4);
		pixel(8'h00, 8'h00, 8'h00);
		pixel(8'hFF, 8'hFF, 8'hFF);
		pixel(8'h80, 8'h80, 8'h80);
		pixel(8'hFF, 8'h00, 8'h00);
		pixel(8'h00, 8'hFF, 8'h00);
		pixel(8'h00, 8'h00, 8'hFF);
		set_geometry(0, 0, 0);
		pixel(8'h7F, 8'h7F, 8'h7F);
		pixel(8'hFF, 8'h00, 8'hFF);
		set_geometry(2047, 65535, 511);
		pixel(8'h40, 8'hC0, 8'h20);
		pixel(8'hFF, 8'hFF, 8'h00);
		pixel(8'h01, 8'hFE, 8'h55);
		set_geometry(MAX_WIDTH, 2, 1);
		pixel(8'hAA, 8'h55, 8'hAA);
		pixel(8'h00, 8'hFF, 8'hFF);
		set_geometry(1, 1, PAL_DEPTH);
		pixel(8'h12, 8'h34, 8'h56);
		pixel(8'hFF, 8'hFF, 8'hFE);
		set_geometry(2, 2, 2);
		repeat (4) random_pixel();

		// Random: mostly whole small images with small palettes, the odd
		// palette entry reloaded mid-image, now and then a large palette or wide row.
		while (pixels_sent < 420) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
			h = $urandom_range(1, 4);
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 256) : $urandom_range(2, 16);
			set_geometry(w, h, n);
			span = w * h * $urandom_range(1, 2);
			if (span > 60) span = 60;
			for (int i = 0; i < span; i++) begin
				if ($urandom_range(0, 15) == 0)
					send(CMD_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom));
				random_pixel();
			end
		end

		drain();
		if (mismatches == 0 && waiting == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/edp_pkg.sv
src/edp_ifs.sv
src/edp_ctrl.sv
src/edp_datapath.sv
src/error_diffusion_palette_dither_core.sv
test/dither_checker.sv
test/tb_top.sv
